// ----- rtl/core/v3au_pkg.sv -----
// Shared constants, types and saturation helpers for the vector arithmetic unit.
package v3au_pkg;

   localparam int DATA_W        = 32;
   localparam int SCALE_W       = 16;
   localparam int OP_W          = 3;
   localparam int STATUS_W      = 2;
   localparam int PROD_W        = 64;
   localparam int WIDE_W        = 66;
   localparam int LANES         = 3;
   localparam int ROOT_BITS     = 32;
   localparam int QUOT_BITS     = 33;
   localparam int DEF_FRAC_BITS = 16;

   // multiply, sum, saturate before the lanes split into root and quotient
   localparam int FRONT_STAGES  = 3;
   // partial products, assembly, then one quotient bit per stage
   localparam int BACK_STAGES   = QUOT_BITS + 2;
   localparam int PIPE_DEPTH    = FRONT_STAGES + BACK_STAGES;

   localparam logic [OP_W-1:0] OP_MAGNITUDE = 3'd0;
   localparam logic [OP_W-1:0] OP_SCALE     = 3'd1;
   localparam logic [OP_W-1:0] OP_ADD       = 3'd2;
   localparam logic [OP_W-1:0] OP_DOT       = 3'd3;
   localparam logic [OP_W-1:0] OP_CROSS     = 3'd4;
   localparam logic [OP_W-1:0] OP_PROJECT   = 3'd5;
   localparam logic [OP_W-1:0] OP_AREA      = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd2;

   localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef logic [LANES-1:0][DATA_W-1:0] vec_type;

   typedef struct packed {
      logic [DATA_W-1:0] val;
      logic              ovf;
   } sat_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      vec_type           r;
      logic              ovf;
      logic [DATA_W-1:0] scalar;
      logic              szero;
      logic              dn;
      logic [PROD_W-1:0] dmag;
      logic [PROD_W-1:0] ssum;
      vec_type           second;
   } merge_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      vec_type           r;
      logic              ovf;
      logic [DATA_W-1:0] scalar;
      logic              szero;
      logic              dn;
   } side_type;

   typedef struct packed {
      vec_type             r;
      logic [DATA_W-1:0]   scalar;
      logic [STATUS_W-1:0] status;
   } result_type;

   // clamp a wide signed value into 32 bits
   function automatic sat_type sat_wide(input logic [WIDE_W-1:0] w);
      sat_type res;
      res.ovf = !((&w[WIDE_W-1:DATA_W-1]) || !(|w[WIDE_W-1:DATA_W-1]));
      if (res.ovf) begin
         res.val = w[WIDE_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
         res.val = w[DATA_W-1:0];
      end
      return res;
   endfunction

   // signed result from sign and unsigned quotient; big means quotient past its bits
   function automatic sat_type sat_mag(input logic neg, input logic big,
                                       input logic [QUOT_BITS-1:0] q);
      sat_type res;
      if (!neg) begin
         res.ovf = big || q[QUOT_BITS-1] || q[DATA_W-1];
         res.val = res.ovf ? SAT_MAX : q[DATA_W-1:0];
      end else begin
         res.ovf = big || q[QUOT_BITS-1] || (q[DATA_W-1] && (|q[DATA_W-2:0]));
         res.val = res.ovf ? SAT_MIN : (~q[DATA_W-1:0] + DATA_W'(1));
      end
      return res;
   endfunction

   function automatic sat_type sat_root(input logic [ROOT_BITS-1:0] root);
      sat_type res;
      res.ovf = root[ROOT_BITS-1];
      res.val = res.ovf ? SAT_MAX : DATA_W'(root);
      return res;
   endfunction

endpackage

// ----- rtl/core/v3au_if.sv -----
// Request and response channel interfaces of the vector arithmetic unit.
interface v3au_req_if;
   logic                                valid;
   logic                                ready;
   logic [v3au_pkg::OP_W-1:0]           operation;
   logic signed [v3au_pkg::DATA_W-1:0]  first_x;
   logic signed [v3au_pkg::DATA_W-1:0]  first_y;
   logic signed [v3au_pkg::DATA_W-1:0]  first_z;
   logic signed [v3au_pkg::DATA_W-1:0]  second_x;
   logic signed [v3au_pkg::DATA_W-1:0]  second_y;
   logic signed [v3au_pkg::DATA_W-1:0]  second_z;
   logic signed [v3au_pkg::SCALE_W-1:0] scale_factor;

   modport source (output valid, operation, first_x, first_y, first_z,
                   second_x, second_y, second_z, scale_factor, input ready);
   modport sink (input valid, operation, first_x, first_y, first_z,
                 second_x, second_y, second_z, scale_factor, output ready);
endinterface

interface v3au_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [v3au_pkg::DATA_W-1:0]   out_x;
   logic signed [v3au_pkg::DATA_W-1:0]   out_y;
   logic signed [v3au_pkg::DATA_W-1:0]   out_z;
   logic signed [v3au_pkg::DATA_W-1:0]   out_scalar;
   logic [v3au_pkg::STATUS_W-1:0]        status;

   modport source (output valid, out_x, out_y, out_z, out_scalar, status, input ready);
   modport sink (input valid, out_x, out_y, out_z, out_scalar, status, output ready);
endinterface

// ----- rtl/core/vector3_arithmetic_unit_top.sv -----
// Vector arithmetic unit top: lanes, merge, root and quotient pipelines, response register.
//
// Requests carry an opcode, two 3D vectors in signed fixed point and an integer
// scale factor; each request yields exactly one response with a vector, a scalar
// and a status (ok, saturated, divide by zero).
// A request is taken on any edge with req_bus.valid and req_bus.ready high.
// Every opcode takes the same path from request to response valid: three
// stages of multiply and merge, 35 stages in which operand setup is followed by
// one root or quotient bit per stage in the square root and the three projection
// dividers, and the response register. Throughput is one request per cycle unless stalled.
// The pipeline moves whenever its last stage is empty or the response register
// is free or being read, so requests keep flowing while a response waits;
// only a full last stage behind a stalled response stops req_bus.ready.
// Synchronous reset drops everything in flight; no state survives between
// requests.
module vector3_arithmetic_unit_top #(
   parameter int FRAC_BITS = v3au_pkg::DEF_FRAC_BITS
) (
   input logic          clock,
   input logic          reset,
   v3au_req_if.sink     req_bus,
   v3au_rsp_if.source   rsp_bus
);

   localparam int LANES = v3au_pkg::LANES;
   localparam int DEPTH = v3au_pkg::PIPE_DEPTH;
   localparam int BACK  = v3au_pkg::BACK_STAGES;

   logic                     en;
   logic [DEPTH-1:0]         vld_ff;
   logic                     rsp_valid_ff, rsp_valid_in;

   v3au_pkg::vec_type        first_vec, second_vec;
   v3au_pkg::vec_type        first1_ff, second1_ff;
   logic [v3au_pkg::OP_W-1:0] op1_ff;
   logic [LANES-1:0][v3au_pkg::PROD_W-1:0] prod_a, prod_b;
   v3au_pkg::merge_type      merged;
   v3au_pkg::side_type       side_ff [BACK];
   v3au_pkg::side_type       side;

   logic [v3au_pkg::ROOT_BITS-1:0] root;
   logic [v3au_pkg::QUOT_BITS-1:0] quot [LANES];
   logic [LANES-1:0]               quot_big, quot_vneg;

   v3au_pkg::sat_type        root_sat;
   v3au_pkg::sat_type        proj_sat [LANES];
   logic                     ovf, div_zero;
   v3au_pkg::result_type     res_in, res_ff;

   assign en = !vld_ff[DEPTH-1] || !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = en;

   assign first_vec  = {req_bus.first_z, req_bus.first_y, req_bus.first_x};
   assign second_vec = {req_bus.second_z, req_bus.second_y, req_bus.second_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_bus.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op1_ff     <= req_bus.operation;
         first1_ff  <= first_vec;
         second1_ff <= second_vec;
      end
   end

   for (genvar c = 0; c < LANES; c++) begin : g_lane
      v3au_mul_lane u_mul (
         .clock        (clock),
         .en           (en),
         .operation    (req_bus.operation),
         .first_c      (first_vec[c]),
         .second_c     (second_vec[c]),
         .first_p      (first_vec[(c+1)%LANES]),
         .second_q     (second_vec[(c+2)%LANES]),
         .first_q      (first_vec[(c+2)%LANES]),
         .second_p     (second_vec[(c+1)%LANES]),
         .scale_factor (req_bus.scale_factor),
         .prod_a       (prod_a[c]),
         .prod_b       (prod_b[c])
      );
   end

   v3au_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
      .clock     (clock),
      .en        (en),
      .operation (op1_ff),
      .first     (first1_ff),
      .second    (second1_ff),
      .prod_a    (prod_a),
      .prod_b    (prod_b),
      .merged    (merged)
   );

   v3au_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .vec   (merged.r),
      .root  (root)
   );

   for (genvar c = 0; c < LANES; c++) begin : g_div
      v3au_div_lane u_div (
         .clock    (clock),
         .en       (en),
         .second_c (merged.second[c]),
         .dmag     (merged.dmag),
         .ssum     (merged.ssum),
         .quot     (quot[c]),
         .big      (quot_big[c]),
         .vneg     (quot_vneg[c])
      );
   end

   // results that are already final ride alongside the root and quotient pipelines
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= '{op: merged.op, r: merged.r, ovf: merged.ovf,
                         scalar: merged.scalar, szero: merged.szero, dn: merged.dn};
         for (int k = 1; k < BACK; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign side = side_ff[BACK-1];

   always_comb begin
      root_sat = v3au_pkg::sat_root(root);
      for (int c = 0; c < LANES; c++) begin
         proj_sat[c] = v3au_pkg::sat_mag(quot_vneg[c] ^ side.dn, quot_big[c], quot[c]);
      end
      res_in   = '0;
      ovf      = 1'b0;
      div_zero = 1'b0;
      case (side.op)
         v3au_pkg::OP_MAGNITUDE: begin
            res_in.scalar = root_sat.val;
            ovf           = root_sat.ovf;
         end
         v3au_pkg::OP_SCALE, v3au_pkg::OP_ADD, v3au_pkg::OP_CROSS: begin
            res_in.r = side.r;
            ovf      = side.ovf;
         end
         v3au_pkg::OP_DOT: begin
            res_in.scalar = side.scalar;
            ovf           = side.ovf;
         end
         v3au_pkg::OP_PROJECT: begin
            if (side.szero) begin
               div_zero = 1'b1;
            end else begin
               for (int c = 0; c < LANES; c++) begin
                  res_in.r[c] = proj_sat[c].val;
                  ovf         = ovf | proj_sat[c].ovf;
               end
            end
         end
         v3au_pkg::OP_AREA: begin
            res_in.scalar = root_sat.val;
            ovf           = side.ovf | root_sat.ovf;
         end
         default: begin
            ovf = 1'b0;
         end
      endcase
      if (div_zero) begin
         res_in.status = v3au_pkg::ST_DIV_ZERO;
      end else if (ovf) begin
         res_in.status = v3au_pkg::ST_OVERFLOW;
      end else begin
         res_in.status = v3au_pkg::ST_OK;
      end
   end

   always_comb begin
      if (vld_ff[DEPTH-1] && en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (vld_ff[DEPTH-1] && en) begin
         res_ff <= res_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.out_x      = res_ff.r[0];
   assign rsp_bus.out_y      = res_ff.r[1];
   assign rsp_bus.out_z      = res_ff.r[2];
   assign rsp_bus.out_scalar = res_ff.scalar;
   assign rsp_bus.status     = res_ff.status;

   // a divide-by-zero response carries all-zero data
   a_div_zero_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.status == v3au_pkg::ST_DIV_ZERO |->
         res_ff.r == '0 && res_ff.scalar == '0)
      else $error("divide by zero response with nonzero data");

   // an empty last stage never blocks requests
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[DEPTH-1] |-> req_bus.ready)
      else $error("request blocked with empty last stage");

   // a response never lands on one that was not taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |-> !(vld_ff[DEPTH-1] && en))
      else $error("pending response overwritten");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (res_ff.status == v3au_pkg::ST_OK ||
                        res_ff.status == v3au_pkg::ST_OVERFLOW ||
                        res_ff.status == v3au_pkg::ST_DIV_ZERO))
      else $error("undefined status code");

endmodule

// ----- rtl/core/v3au_mul_lane.sv -----
// One component lane: operand select and two registered 32x32 signed multiplies.
module v3au_mul_lane (
   input  logic                          clock,
   input  logic                          en,
   input  logic [v3au_pkg::OP_W-1:0]     operation,
   input  logic [v3au_pkg::DATA_W-1:0]   first_c,
   input  logic [v3au_pkg::DATA_W-1:0]   second_c,
   input  logic [v3au_pkg::DATA_W-1:0]   first_p,
   input  logic [v3au_pkg::DATA_W-1:0]   second_q,
   input  logic [v3au_pkg::DATA_W-1:0]   first_q,
   input  logic [v3au_pkg::DATA_W-1:0]   second_p,
   input  logic [v3au_pkg::SCALE_W-1:0]  scale_factor,
   output logic [v3au_pkg::PROD_W-1:0]   prod_a,
   output logic [v3au_pkg::PROD_W-1:0]   prod_b
);

   logic signed [v3au_pkg::DATA_W-1:0] a1, b1, a2, b2;
   logic signed [v3au_pkg::PROD_W-1:0] prod_a_in, prod_b_in, prod_a_ff, prod_b_ff;

   always_comb begin
      a1 = '0;
      b1 = '0;
      a2 = '0;
      b2 = '0;
      case (operation)
         v3au_pkg::OP_SCALE: begin
            a1 = $signed(first_c);
            b1 = v3au_pkg::DATA_W'($signed(scale_factor));
         end
         v3au_pkg::OP_DOT, v3au_pkg::OP_PROJECT: begin
            a1 = $signed(first_c);
            b1 = $signed(second_c);
            a2 = $signed(second_c);
            b2 = $signed(second_c);
         end
         v3au_pkg::OP_CROSS, v3au_pkg::OP_AREA: begin
            a1 = $signed(first_p);
            b1 = $signed(second_q);
            a2 = $signed(first_q);
            b2 = $signed(second_p);
         end
         default: begin
            a1 = '0;
         end
      endcase
      prod_a_in = v3au_pkg::PROD_W'(a1) * v3au_pkg::PROD_W'(b1);
      prod_b_in = v3au_pkg::PROD_W'(a2) * v3au_pkg::PROD_W'(b2);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
      end
   end

   assign prod_a = prod_a_ff;
   assign prod_b = prod_b_ff;

endmodule

// ----- rtl/core/v3au_merge.sv -----
// Merge stage: combines lane products into sums, differences and saturated lane values.
module v3au_merge #(
   parameter int FRAC_BITS = v3au_pkg::DEF_FRAC_BITS
) (
   input  logic                                              clock,
   input  logic                                              en,
   input  logic [v3au_pkg::OP_W-1:0]                         operation,
   input  v3au_pkg::vec_type                                 first,
   input  v3au_pkg::vec_type                                 second,
   input  logic [v3au_pkg::LANES-1:0][v3au_pkg::PROD_W-1:0]  prod_a,
   input  logic [v3au_pkg::LANES-1:0][v3au_pkg::PROD_W-1:0]  prod_b,
   output v3au_pkg::merge_type                               merged
);

   logic signed [v3au_pkg::WIDE_W-1:0] diff [v3au_pkg::LANES];
   logic signed [v3au_pkg::WIDE_W-1:0] w_in [v3au_pkg::LANES];
   logic signed [v3au_pkg::WIDE_W-1:0] w_ff [v3au_pkg::LANES];
   logic signed [v3au_pkg::WIDE_W-1:0] dot_in, dot_ff, dot_sh, dot_neg;
   logic [v3au_pkg::PROD_W-1:0]        ssum_in, ssum_ff;
   logic [v3au_pkg::OP_W-1:0]          op_ff;
   v3au_pkg::vec_type                  second_ff;
   v3au_pkg::sat_type                  lane_sat [v3au_pkg::LANES];
   v3au_pkg::sat_type                  dot_sat;
   logic                               lane_ovf;
   v3au_pkg::merge_type                merged_in, merged_ff;

   // sums across lanes
   always_comb begin
      dot_in  = '0;
      ssum_in = '0;
      for (int c = 0; c < v3au_pkg::LANES; c++) begin
         dot_in  = dot_in + v3au_pkg::WIDE_W'($signed(prod_a[c]));
         ssum_in = ssum_in + prod_b[c];
         diff[c] = v3au_pkg::WIDE_W'($signed(prod_a[c]))
                 - v3au_pkg::WIDE_W'($signed(prod_b[c]));
         case (operation)
            v3au_pkg::OP_MAGNITUDE: w_in[c] = v3au_pkg::WIDE_W'($signed(first[c]));
            v3au_pkg::OP_SCALE:     w_in[c] = v3au_pkg::WIDE_W'($signed(prod_a[c]));
            v3au_pkg::OP_ADD:       w_in[c] = v3au_pkg::WIDE_W'($signed(first[c]))
                                            + v3au_pkg::WIDE_W'($signed(second[c]));
            v3au_pkg::OP_CROSS, v3au_pkg::OP_AREA: w_in[c] = diff[c] >>> FRAC_BITS;
            default:                w_in[c] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op_ff     <= operation;
         second_ff <= second;
         dot_ff    <= dot_in;
         ssum_ff   <= ssum_in;
         for (int c = 0; c < v3au_pkg::LANES; c++) begin
            w_ff[c] <= w_in[c];
         end
      end
   end

   // saturation and projection operands
   always_comb begin
      lane_ovf = 1'b0;
      for (int c = 0; c < v3au_pkg::LANES; c++) begin
         lane_sat[c]     = v3au_pkg::sat_wide(w_ff[c]);
         lane_ovf        = lane_ovf | lane_sat[c].ovf;
         merged_in.r[c]  = lane_sat[c].val;
      end
      dot_sh  = dot_ff >>> FRAC_BITS;   // floor toward minus infinity
      dot_sat = v3au_pkg::sat_wide(dot_sh);
      dot_neg = -dot_ff;

      merged_in.op     = op_ff;
      merged_in.scalar = dot_sat.val;
      case (op_ff)
         v3au_pkg::OP_DOT:       merged_in.ovf = dot_sat.ovf;
         v3au_pkg::OP_MAGNITUDE: merged_in.ovf = 1'b0;
         default:                merged_in.ovf = lane_ovf;
      endcase
      merged_in.dn     = dot_ff[v3au_pkg::WIDE_W-1];
      merged_in.dmag   = merged_in.dn ? dot_neg[v3au_pkg::PROD_W-1:0]
                                      : dot_ff[v3au_pkg::PROD_W-1:0];
      merged_in.ssum   = ssum_ff;
      merged_in.szero  = (ssum_ff == '0);
      merged_in.second = second_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         merged_ff <= merged_in;
      end
   end

   assign merged = merged_ff;

endmodule

// ----- rtl/core/v3au_div_lane.sv -----
// Projection lane: |second_c| * |dot| divided by |second|^2, one quotient bit per stage.
module v3au_div_lane (
   input  logic                              clock,
   input  logic                              en,
   input  logic [v3au_pkg::DATA_W-1:0]       second_c,
   input  logic [v3au_pkg::PROD_W-1:0]       dmag,
   input  logic [v3au_pkg::PROD_W-1:0]       ssum,
   output logic [v3au_pkg::QUOT_BITS-1:0]    quot,
   output logic                              big,
   output logic                              vneg
);

   localparam int QB  = v3au_pkg::QUOT_BITS;
   localparam int PW  = v3au_pkg::PROD_W;
   localparam int DW  = v3au_pkg::DATA_W;
   localparam int NUM = PW + DW;

   logic [DW-1:0]  amag;
   logic [PW-1:0]  pl_ff, ph_ff, s4_ff;
   logic           vneg4_ff;
   logic [NUM-1:0] num;

   logic [PW-1:0]  rem_ff  [QB+1];
   logic [QB-1:0]  low_ff  [QB+1];
   logic [QB-1:0]  q_ff    [QB+1];
   logic [PW-1:0]  s_ff    [QB+1];
   logic           big_ff  [QB+1];
   logic           vneg_ff [QB+1];

   assign amag = second_c[DW-1] ? (~second_c + DW'(1)) : second_c;

   // partial products of a 32x64 multiply
   always_ff @(posedge clock) begin
      if (en) begin
         pl_ff    <= PW'(amag) * PW'(dmag[DW-1:0]);
         ph_ff    <= PW'(amag) * PW'(dmag[PW-1:DW]);
         s4_ff    <= ssum;
         vneg4_ff <= second_c[DW-1];
      end
   end

   assign num = NUM'(pl_ff) + {ph_ff, {DW{1'b0}}};

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= PW'(num[NUM-1:QB]);
         low_ff[0]  <= num[QB-1:0];
         q_ff[0]    <= '0;
         s_ff[0]    <= s4_ff;
         big_ff[0]  <= (PW'(num[NUM-1:QB]) >= s4_ff);
         vneg_ff[0] <= vneg4_ff;
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_step
      logic [PW:0] rem2, sub;
      logic        ge;
      assign rem2 = {rem_ff[k], low_ff[k][QB-1]};
      assign ge   = rem2 >= {1'b0, s_ff[k]};
      assign sub  = rem2 - {1'b0, s_ff[k]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= ge ? sub[PW-1:0] : rem2[PW-1:0];
            low_ff[k+1]  <= {low_ff[k][QB-2:0], 1'b0};
            q_ff[k+1]    <= {q_ff[k][QB-2:0], ge};
            s_ff[k+1]    <= s_ff[k];
            big_ff[k+1]  <= big_ff[k];
            vneg_ff[k+1] <= vneg_ff[k];
         end
      end
   end

   assign quot = q_ff[QB];
   assign big  = big_ff[QB];
   assign vneg = vneg_ff[QB];

endmodule

// ----- rtl/core/v3au_sqrt.sv -----
// Sum of squares of a vector and its floor square root, two radicand bits per stage.
module v3au_sqrt (
   input  logic                              clock,
   input  logic                              en,
   input  v3au_pkg::vec_type                 vec,
   output logic [v3au_pkg::ROOT_BITS-1:0]    root
);

   localparam int RB = v3au_pkg::ROOT_BITS;
   localparam int PW = v3au_pkg::PROD_W;
   localparam int RW = RB + 2;

   logic signed [PW-1:0] sq_ff [v3au_pkg::LANES];
   logic [PW-1:0]        sum_in;

   logic [RW-1:0] rem_ff  [RB+1];
   logic [RB-1:0] rt_ff   [RB+1];
   logic [PW-1:0] rad_ff  [RB+1];
   logic [RB-1:0] root_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < v3au_pkg::LANES; c++) begin
            sq_ff[c] <= PW'($signed(vec[c])) * PW'($signed(vec[c]));
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int c = 0; c < v3au_pkg::LANES; c++) begin
         sum_in = sum_in + $unsigned(sq_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= '0;
         rt_ff[0]  <= '0;
         rad_ff[0] <= sum_in;
      end
   end

   for (genvar k = 0; k < RB; k++) begin : g_step
      logic [RW+1:0] rem2, trial, sub;
      logic          ge;
      assign rem2  = {rem_ff[k], rad_ff[k][PW-1:PW-2]};
      assign trial = (RW+2)'({rt_ff[k], 2'b01});
      assign ge    = rem2 >= trial;
      assign sub   = rem2 - trial;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? sub[RW-1:0] : rem2[RW-1:0];
            rt_ff[k+1]  <= {rt_ff[k][RB-2:0], ge};
            rad_ff[k+1] <= {rad_ff[k][PW-3:0], 2'b00};
         end
      end
   end

   // extra stage lines the root up with the quotient lanes
   always_ff @(posedge clock) begin
      if (en) begin
         root_ff <= rt_ff[RB];
      end
   end

   assign root = root_ff;

endmodule
